[sv/rbfb_pkg.sv]
// shared types, codes and helpers of the rigid body floor bounce stepper
package rbfb_pkg;

    localparam int IDX_W     = 6;
    localparam int SEL_W     = 5;
    localparam int REG_IDX_W = 3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] KIND_STATIC    = 2'd0;
    localparam logic [1:0] KIND_KINEMATIC = 2'd1;
    localparam logic [1:0] KIND_DYNAMIC   = 2'd2;

    localparam logic [SEL_W-1:0] FS_KIND    = 5'd0;
    localparam logic [SEL_W-1:0] FS_POS_X   = 5'd1;
    localparam logic [SEL_W-1:0] FS_POS_Y   = 5'd2;
    localparam logic [SEL_W-1:0] FS_VEL_X   = 5'd3;
    localparam logic [SEL_W-1:0] FS_VEL_Y   = 5'd4;
    localparam logic [SEL_W-1:0] FS_IMP_X   = 5'd5;
    localparam logic [SEL_W-1:0] FS_IMP_Y   = 5'd6;
    localparam logic [SEL_W-1:0] FS_FRC_X   = 5'd7;
    localparam logic [SEL_W-1:0] FS_FRC_Y   = 5'd8;
    localparam logic [SEL_W-1:0] FS_ACC_X   = 5'd9;
    localparam logic [SEL_W-1:0] FS_ACC_Y   = 5'd10;
    localparam logic [SEL_W-1:0] FS_MASS    = 5'd11;
    localparam logic [SEL_W-1:0] FS_INVMASS = 5'd12;
    localparam logic [SEL_W-1:0] FS_DAMPING = 5'd13;
    localparam logic [SEL_W-1:0] FS_RESTIT  = 5'd14;
    localparam logic [SEL_W-1:0] FS_FRICT   = 5'd15;
    localparam logic [SEL_W-1:0] FS_RADIUS  = 5'd16;

    localparam logic [REG_IDX_W-1:0] REG_GRAVITY_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_LEVEL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BOUNCE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP   = 3'd4;

    localparam logic signed [31:0] GRAVITY_X_RST   = 32'sd0;
    localparam logic signed [31:0] GRAVITY_Y_RST   = -32'sd642253;
    localparam logic signed [31:0] FLOOR_LEVEL_RST = -32'sd327680;
    localparam logic [30:0]        MIN_BOUNCE_RST  = 31'd22938;
    localparam logic [30:0]        TIME_STEP_RST   = 31'd1092;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] imp_x;
        logic signed [31:0] imp_y;
        logic signed [31:0] frc_x;
        logic signed [31:0] frc_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] mass;
        logic signed [31:0] inv;
        logic signed [31:0] damp;
        logic signed [31:0] rest;
        logic signed [31:0] fric;
        logic signed [31:0] rad;
    } t_row;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
    } t_mem_req;

    function automatic logic signed [32:0] f_ext33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    function automatic logic signed [31:0] f_sat_add(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [32:0] s;
        s = f_ext33(a) + f_ext33(b);
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

endpackage

[sv/rbfb_in_if.sv]
// input channel: property writes and step requests
interface rbfb_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [5:0]        body_index;
    logic [4:0]        field_select;
    logic signed [31:0] write_value;

    modport source (output valid, cmd, body_index, field_select, write_value, input ready);
    modport sink   (input valid, cmd, body_index, field_select, write_value, output ready);
endinterface

[sv/rbfb_out_if.sv]
// output channel: stepped body state
interface rbfb_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         out_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               step_status;
    logic               floor_hit;

    modport source (output valid, out_index, pos_x, pos_y, vel_x, vel_y, step_status,
                    floor_hit, input ready);
    modport sink   (input valid, out_index, pos_x, pos_y, vel_x, vel_y, step_status,
                    floor_hit, output ready);
endinterface

[sv/rbfb_mem.sv]
// body table: one row per body, registered read, per-row valid bits
module rbfb_mem #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbfb_pkg::t_mem_req i_req,
    input  rbfb_pkg::t_row    i_wr_data,
    output rbfb_pkg::t_row    o_rd_data
);
    import rbfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_row             r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_row             r_rd;
    logic             r_rd_vld;
    logic [AW-1:0]    addr;

    assign addr = i_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd     <= r_mem[addr];
            r_rd_vld <= r_vld[addr];
        end
    end

    // rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;
endmodule

[sv/rbfb_mul.sv]
// fixed point multiply: operand regs, product reg, round half up and saturate
module rbfb_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_ld,
    input  logic signed [32:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_res
);
    import rbfb_pkg::*;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;

    logic signed [32:0] r_a;
    logic signed [31:0] r_b;
    logic signed [64:0] r_p;
    logic signed [65:0] rnd;

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_p <= r_a * r_b;
    end

    assign rnd = ($signed({r_p[64], r_p}) + HALF) >>> FRAC_BITS;

    always_comb begin
        if (rnd > MAXV) begin
            o_res = 32'sh7fff_ffff;
        end else if (rnd < MINV) begin
            o_res = 32'sh8000_0000;
        end else begin
            o_res = rnd[31:0];
        end
    end
endmodule

[sv/rbfb_div.sv]
// restoring divider: (v << FRAC_BITS) / d, truncated toward zero, saturated
module rbfb_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [33:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_q
);
    import rbfb_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_sh;
    logic [33:0]   r_rem;
    logic [33:0]   r_dab;
    logic          r_neg;
    logic [34:0]   trial;
    logic          ge;
    logic [31:0]   num_abs;
    logic          big;

    assign num_abs = i_num[31] ? 32'(-i_num) : i_num;
    assign trial   = {r_rem, r_sh[NW-1]};
    assign ge      = trial >= {1'b0, r_dab};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= {num_abs, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_dab <= i_den[33] ? 34'(-i_den) : i_den;
            r_neg <= i_num[31] ^ i_den[33];
        end else if (r_busy) begin
            r_rem <= ge ? 34'(trial - {1'b0, r_dab}) : trial[33:0];
            r_sh  <= {r_sh[NW-2:0], ge};
        end
    end

    assign big    = |r_sh[NW-1:32];
    assign o_done = r_done;

    always_comb begin
        if (!r_neg) begin
            o_q = (big || r_sh[31]) ? 32'sh7fff_ffff : r_sh[31:0];
        end else if (big || (r_sh[31] && |r_sh[30:0])) begin
            o_q = 32'sh8000_0000;
        end else begin
            o_q = 32'(-r_sh[31:0]);
        end
    end
endmodule

[sv/rigid_body_floor_bounce_step_core.sv]
// Rigid circle body stepper with floor bounce. Bodies live in one table memory, one row
// per body, with a registered read, and written back by the sequencer. A property
// write reads the row and writes it back with the new field. A step runs on one shared
// multiplier and one bit-serial divider: a kinematic body uses only the multiplier, a
// dynamic body also takes two quotients, and a body that hits the floor while falling
// adds a restitution product unless it falls slower than the minimum bounce, and a
// dynamic one then a friction product and one more quotient. Skipped bodies answer
// without a step.
// One item is processed at a time; the finished result waits in an output register.
module rigid_body_floor_bounce_step_core #(
    parameter int BODY_COUNT = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rbfb_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    rbfb_in_if.sink                        i_in,
    rbfb_out_if.source                     o_out
);
    import rbfb_pkg::*;

    localparam int DEPTH = (BODY_COUNT < 64) ? BODY_COUNT : 64;
    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_IMPX  = 5'd2;
    localparam logic [4:0] S_IMPY  = 5'd3;
    localparam logic [4:0] S_GRX   = 5'd4;
    localparam logic [4:0] S_GRY   = 5'd5;
    localparam logic [4:0] S_FIX   = 5'd6;
    localparam logic [4:0] S_FDX   = 5'd7;
    localparam logic [4:0] S_FIY   = 5'd8;
    localparam logic [4:0] S_FDY   = 5'd9;
    localparam logic [4:0] S_ACCX  = 5'd10;
    localparam logic [4:0] S_ACCY  = 5'd11;
    localparam logic [4:0] S_DMP   = 5'd12;
    localparam logic [4:0] S_DIVX  = 5'd13;
    localparam logic [4:0] S_DIVY  = 5'd14;
    localparam logic [4:0] S_POSX  = 5'd15;
    localparam logic [4:0] S_POSY  = 5'd16;
    localparam logic [4:0] S_FLOOR = 5'd17;
    localparam logic [4:0] S_REST  = 5'd18;
    localparam logic [4:0] S_FRC   = 5'd19;
    localparam logic [4:0] S_DIVF  = 5'd20;
    localparam logic [4:0] S_WB    = 5'd21;
    localparam logic [4:0] S_FIN   = 5'd22;

    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_PROD = 2'd1;
    localparam logic [1:0] PH_USE  = 2'd2;

    // config registers
    logic signed [31:0] r_grav_x, r_grav_y, r_floor;
    logic [30:0]        r_minb, r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_x <= GRAVITY_X_RST;
            r_grav_y <= GRAVITY_Y_RST;
            r_floor  <= FLOOR_LEVEL_RST;
            r_minb   <= MIN_BOUNCE_RST;
            r_dt     <= TIME_STEP_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_GRAVITY_X:   r_grav_x <= i_cfg_data;
                REG_GRAVITY_Y:   r_grav_y <= i_cfg_data;
                REG_FLOOR_LEVEL: r_floor  <= i_cfg_data;
                REG_MIN_BOUNCE:  r_minb   <= i_cfg_data[30:0];
                REG_TIME_STEP:   r_dt     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic [4:0]         r_state, n_state;
    logic [1:0]         r_ph, n_ph;
    logic               r_cmd, n_cmd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SEL_W-1:0]   r_sel, n_sel;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_px, n_px, r_py, n_py, r_vx, n_vx, r_vy, n_vy;
    logic signed [31:0] r_fx, n_fx, r_fy, n_fy, r_tmp, n_tmp;
    logic signed [33:0] r_d, n_d;
    logic               r_stat, n_stat, r_hit, n_hit;

    logic               r_ov, n_ov;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic signed [31:0] r_o_px, n_o_px, r_o_py, n_o_py, r_o_vx, n_o_vx, r_o_vy, n_o_vy;
    logic               r_o_stat, n_o_stat, r_o_hit, n_o_hit;

    t_mem_req           mreq;
    t_row               row, wdata;
    logic               is_mul, mul_ld;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b, m;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_q;
    logic               in_acc, idx_ok, is_dyn, use_now;
    logic signed [31:0] dt_s;
    logic signed [32:0] inc, py_low;
    logic               below;

    rbfb_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mreq),
        .i_wr_data (wdata),
        .o_rd_data (row)
    );

    rbfb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_ld  (mul_ld),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (m)
    );

    rbfb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);
    assign idx_ok     = {1'b0, r_idx} < 7'(DEPTH);
    assign is_dyn     = (row.kind == KIND_DYNAMIC);
    assign dt_s       = {1'b0, r_dt};
    assign use_now    = (r_ph == PH_USE);
    assign inc        = -f_ext33(r_vy);
    assign py_low     = f_ext33(r_py) - f_ext33(row.rad);
    assign below      = py_low < f_ext33(r_floor);
    assign div_num    = (r_state == S_DIVY) ? r_vy : r_vx;
    assign mul_ld     = is_mul && (r_ph == PH_LOAD);

    always_comb begin
        n_state = r_state;  n_ph = r_ph;
        n_cmd = r_cmd;  n_idx = r_idx;  n_sel = r_sel;  n_val = r_val;
        n_px = r_px;  n_py = r_py;  n_vx = r_vx;  n_vy = r_vy;
        n_fx = r_fx;  n_fy = r_fy;  n_tmp = r_tmp;  n_d = r_d;
        n_stat = r_stat;  n_hit = r_hit;
        n_ov = r_ov && !o_out.ready;
        n_o_idx = r_o_idx;  n_o_px = r_o_px;  n_o_py = r_o_py;
        n_o_vx = r_o_vx;  n_o_vy = r_o_vy;  n_o_stat = r_o_stat;  n_o_hit = r_o_hit;
        mreq = '0;  wdata = row;
        is_mul = 1'b0;  mul_a = '0;  mul_b = '0;  div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = i_in.cmd;  n_idx = i_in.body_index;
                    n_sel = i_in.field_select;  n_val = i_in.write_value;
                    mreq.rd_en = 1'b1;  mreq.addr = i_in.body_index;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_hit = 1'b0;  n_stat = 1'b1;
                if (r_cmd == CMD_WRITE) begin
                    mreq.addr = r_idx;
                    mreq.wr_en = idx_ok && (r_sel <= FS_RADIUS);
                    unique case (r_sel)
                        FS_KIND:    wdata.kind  = r_val[1:0];
                        FS_POS_X:   wdata.px    = r_val;
                        FS_POS_Y:   wdata.py    = r_val;
                        FS_VEL_X:   wdata.vx    = r_val;
                        FS_VEL_Y:   wdata.vy    = r_val;
                        FS_IMP_X:   wdata.imp_x = r_val;
                        FS_IMP_Y:   wdata.imp_y = r_val;
                        FS_FRC_X:   wdata.frc_x = r_val;
                        FS_FRC_Y:   wdata.frc_y = r_val;
                        FS_ACC_X:   wdata.acc_x = r_val;
                        FS_ACC_Y:   wdata.acc_y = r_val;
                        FS_MASS:    wdata.mass  = r_val;
                        FS_INVMASS: wdata.inv   = r_val;
                        FS_DAMPING: wdata.damp  = r_val;
                        FS_RESTIT:  wdata.rest  = r_val;
                        FS_FRICT:   wdata.fric  = r_val;
                        FS_RADIUS:  wdata.rad   = r_val;
                        default: ;
                    endcase
                    n_state = S_IDLE;
                end else if (!idx_ok) begin
                    n_px = '0;  n_py = '0;  n_vx = '0;  n_vy = '0;
                    n_state = S_FIN;
                end else begin
                    n_px = row.px;  n_py = row.py;  n_vx = row.vx;  n_vy = row.vy;
                    if (row.kind == KIND_STATIC || (is_dyn && row.inv <= 0)) begin
                        n_state = S_FIN;
                    end else begin
                        n_stat = 1'b0;
                        priority if (is_dyn) n_state = S_IMPX;
                        else if (row.kind == KIND_KINEMATIC) n_state = S_ACCX;
                        else n_state = S_POSX;
                    end
                end
            end
            S_IMPX: begin
                is_mul = 1'b1;  mul_a = f_ext33(row.imp_x);  mul_b = row.inv;
                if (use_now) begin n_vx = f_sat_add(r_vx, m); n_state = S_IMPY; end
            end
            S_IMPY: begin
                is_mul = 1'b1;  mul_a = f_ext33(row.imp_y);  mul_b = row.inv;
                if (use_now) begin n_vy = f_sat_add(r_vy, m); n_state = S_GRX; end
            end
            S_GRX: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_grav_x);  mul_b = row.mass;
                if (use_now) begin n_fx = f_sat_add(row.frc_x, m); n_state = S_GRY; end
            end
            S_GRY: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_grav_y);  mul_b = row.mass;
                if (use_now) begin n_fy = f_sat_add(row.frc_y, m); n_state = S_FIX; end
            end
            S_FIX: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_fx);  mul_b = row.inv;
                if (use_now) begin n_tmp = m; n_state = S_FDX; end
            end
            S_FDX: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_tmp);  mul_b = dt_s;
                if (use_now) begin n_vx = f_sat_add(r_vx, m); n_state = S_FIY; end
            end
            S_FIY: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_fy);  mul_b = row.inv;
                if (use_now) begin n_tmp = m; n_state = S_FDY; end
            end
            S_FDY: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_tmp);  mul_b = dt_s;
                if (use_now) begin n_vy = f_sat_add(r_vy, m); n_state = S_ACCX; end
            end
            S_ACCX: begin
                is_mul = 1'b1;  mul_a = f_ext33(row.acc_x);  mul_b = dt_s;
                if (use_now) begin n_vx = f_sat_add(r_vx, m); n_state = S_ACCY; end
            end
            S_ACCY: begin
                is_mul = 1'b1;  mul_a = f_ext33(row.acc_y);  mul_b = dt_s;
                if (use_now) begin
                    n_vy = f_sat_add(r_vy, m);
                    n_state = is_dyn ? S_DMP : S_POSX;
                end
            end
            S_DMP: begin
                is_mul = 1'b1;  mul_a = f_ext33(row.damp);  mul_b = dt_s;
                if (use_now) begin n_d = ONE + {{2{m[31]}}, m}; n_state = S_DIVX; end
            end
            S_DIVX, S_DIVY, S_DIVF: begin
                // zero divisor leaves the velocity as is
                if (r_ph == PH_LOAD) begin
                    if (r_d == '0) begin
                        priority if (r_state == S_DIVX) n_state = S_DIVY;
                        else if (r_state == S_DIVY) n_state = S_POSX;
                        else n_state = S_WB;
                    end else begin
                        div_start = 1'b1;
                        n_ph = PH_PROD;
                    end
                end else if (div_done) begin
                    n_ph = PH_LOAD;
                    priority if (r_state == S_DIVY) begin
                        n_vy = div_q;  n_state = S_POSX;
                    end else if (r_state == S_DIVX) begin
                        n_vx = div_q;  n_state = S_DIVY;
                    end else begin
                        n_vx = div_q;  n_state = S_WB;
                    end
                end
            end
            S_POSX: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_vx);  mul_b = dt_s;
                if (use_now) begin n_px = f_sat_add(r_px, m); n_state = S_POSY; end
            end
            S_POSY: begin
                is_mul = 1'b1;  mul_a = f_ext33(r_vy);  mul_b = dt_s;
                if (use_now) begin n_py = f_sat_add(r_py, m); n_state = S_FLOOR; end
            end
            S_FLOOR: begin
                n_state = S_WB;
                if (below) begin
                    n_hit = 1'b1;
                    n_py = f_sat_add(r_floor, row.rad);
                    if (r_vy < 0) begin
                        if (inc < $signed({2'b00, r_minb})) begin
                            n_vy = '0;
                            n_state = is_dyn ? S_FRC : S_WB;
                        end else begin
                            n_state = S_REST;
                        end
                    end
                end
            end
            S_REST: begin
                is_mul = 1'b1;  mul_a = inc;  mul_b = row.rest;
                if (use_now) begin n_vy = m; n_state = is_dyn ? S_FRC : S_WB; end
            end
            S_FRC: begin
                is_mul = 1'b1;  mul_a = f_ext33(row.fric);  mul_b = dt_s;
                if (use_now) begin n_d = ONE + {{2{m[31]}}, m}; n_state = S_DIVF; end
            end
            S_WB: begin
                mreq.wr_en = 1'b1;  mreq.addr = r_idx;
                wdata.px = r_px;  wdata.py = r_py;  wdata.vx = r_vx;  wdata.vy = r_vy;
                if (is_dyn) begin
                    wdata.imp_x = '0;  wdata.imp_y = '0;
                    wdata.frc_x = '0;  wdata.frc_y = '0;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_o_idx = r_idx;  n_o_px = r_px;  n_o_py = r_py;
                    n_o_vx = r_vx;  n_o_vy = r_vy;
                    n_o_stat = r_stat;  n_o_hit = r_hit;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (is_mul) begin
            n_ph = use_now ? PH_LOAD : (r_ph + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_LOAD;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;  r_idx <= n_idx;  r_sel <= n_sel;  r_val <= n_val;
        r_px <= n_px;  r_py <= n_py;  r_vx <= n_vx;  r_vy <= n_vy;
        r_fx <= n_fx;  r_fy <= n_fy;  r_tmp <= n_tmp;  r_d <= n_d;
        r_stat <= n_stat;  r_hit <= n_hit;
        r_o_idx <= n_o_idx;  r_o_px <= n_o_px;  r_o_py <= n_o_py;
        r_o_vx <= n_o_vx;  r_o_vy <= n_o_vy;  r_o_stat <= n_o_stat;  r_o_hit <= n_o_hit;
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_index   = r_o_idx;
    assign o_out.pos_x       = r_o_px;
    assign o_out.pos_y       = r_o_py;
    assign o_out.vel_x       = r_o_vx;
    assign o_out.vel_y       = r_o_vy;
    assign o_out.step_status = r_o_stat;
    assign o_out.floor_hit   = r_o_hit;
endmodule

[sv/rbfb_checker.sv]
// port-level checks of the stepper, bound to the top level
module rbfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_out_index,
    input logic [31:0] i_out_pos_y,
    input logic [31:0] i_out_vel_y,
    input logic        i_out_status,
    input logic        i_out_hit
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
            && $stable(i_out_pos_y) && $stable(i_out_vel_y))
        else $error("result changed while stalled");

    a_skip_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> !i_out_hit)
        else $error("skipped body reports floor hit");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without an item in flight");
endmodule

bind rigid_body_floor_bounce_step_core rbfb_checker u_rbfb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_index  (o_out.out_index),
    .i_out_pos_y  (o_out.pos_y),
    .i_out_vel_y  (o_out.vel_y),
    .i_out_status (o_out.step_status),
    .i_out_hit    (o_out.floor_hit)
);
